/* rtl/ptdt_pkg.sv */
// ----------------------------------------------------------------------------
// ptdt_pkg: shared types and constants of the trial-division primality tester
// Command codes, status codes, field widths and the controller state type.
// ----------------------------------------------------------------------------
package ptdt_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 256;

  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int PRIME_W  = 16;

  // The divider retires this many quotient bits per cycle.
  localparam int DIV_BITS_PER_CYCLE = 2;
  localparam int DIV_STEPS          = VALUE_W / DIV_BITS_PER_CYCLE;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [PRIME_W-1:0]  prime_t;

  localparam kind_t KIND_CLEAR  = 2'd0;
  localparam kind_t KIND_APPEND = 2'd1;
  localparam kind_t KIND_TEST   = 2'd2;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_FULL      = 2'd1;
  localparam status_t STATUS_TOO_LARGE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_FIN
  } state_t;

endpackage

/* rtl/ptdt_if.sv */
// ----------------------------------------------------------------------------
// ptdt_if: valid/ready channels of the trial-division primality tester
// One interface for command items and one for result items.
// ----------------------------------------------------------------------------
interface ptdt_in_if;
  logic              valid;
  logic              ready;
  ptdt_pkg::kind_t   kind;
  ptdt_pkg::value_t  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface ptdt_out_if;
  logic              valid;
  logic              ready;
  ptdt_pkg::status_t status;
  logic              prime_flag;
  ptdt_pkg::prime_t  divisor;

  modport source (output valid, output status, output prime_flag, output divisor,
                  input ready);
  modport sink   (input valid, input status, input prime_flag, input divisor,
                  output ready);
endinterface

/* rtl/prime_trial_division_tester.sv */
// ----------------------------------------------------------------------------
// prime_trial_division_tester: trial-division primality tester
// Clear and append items go from the idle state through S_FIN to the output
// register. A test walks the table entries in order: for each entry the
// synchronous table read and square compare, then the 2-bit-per-step
// remainder divider on each nonzero entry.
// Synchronous active-low reset empties the table count and the output.
// ----------------------------------------------------------------------------
module prime_trial_division_tester #(
  parameter int TABLE_DEPTH = ptdt_pkg::DEFAULT_TABLE_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  ptdt_in_if.sink    in_ch,
  ptdt_out_if.source out_ch
);
  import ptdt_pkg::*;

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // Base prime table with a registered read: data appears in the cycle after the address is presented.
  prime_t mem [TABLE_DEPTH];
  prime_t rd_data_r;
  logic   wr_en;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  walk_r, walk_nxt;
  logic [CNT_W-1:0]  walk_inc;
  value_t            cand_r, cand_nxt;
  prime_t            p_r, p_nxt;
  prime_t            rem_r, rem_nxt;
  value_t            dsh_r, dsh_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  status_t           res_status_r, res_status_nxt;
  logic              res_prime_r, res_prime_nxt;
  prime_t            res_div_r, res_div_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_prime_r, out_prime_nxt;
  prime_t            out_div_r, out_div_nxt;
  value_t            sq;
  logic [PRIME_W:0]  trial;
  prime_t            rem_step;
  value_t            dsh_step;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.prime_flag = out_prime_r;
  assign out_ch.divisor    = out_div_r;

  assign walk_inc = walk_r + CNT_W'(1);
  assign sq       = VALUE_W'({16'd0, rd_data_r} * {16'd0, rd_data_r});

  // Remainder steps of the restoring divider for this cycle.
  always_comb begin
    rem_step = rem_r;
    dsh_step = dsh_r;
    for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
      trial = {rem_step, dsh_step[VALUE_W-1]};
      if (trial >= {1'b0, p_r}) begin
        trial = trial - {1'b0, p_r};
      end
      rem_step = trial[PRIME_W-1:0];
      dsh_step = {dsh_step[VALUE_W-2:0], 1'b0};
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    walk_nxt       = walk_r;
    cand_nxt       = cand_r;
    p_nxt          = p_r;
    rem_nxt        = rem_r;
    dsh_nxt        = dsh_r;
    step_nxt       = step_r;
    res_status_nxt = res_status_r;
    res_prime_nxt  = res_prime_r;
    res_div_nxt    = res_div_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_prime_nxt  = out_prime_r;
    out_div_nxt    = out_div_r;
    wr_en          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          res_status_nxt = STATUS_OK;
          res_prime_nxt  = 1'b0;
          res_div_nxt    = '0;
          state_nxt      = S_FIN;
          unique case (in_ch.kind)
            KIND_CLEAR: begin
              count_nxt = '0;
            end
            KIND_APPEND: begin
              if (|in_ch.value[VALUE_W-1:PRIME_W]) begin
                res_status_nxt = STATUS_TOO_LARGE;
              end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
                res_status_nxt = STATUS_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            KIND_TEST: begin
              cand_nxt = in_ch.value;
              if (in_ch.value >= VALUE_W'(2)) begin
                if (count_r == '0) begin
                  res_prime_nxt = 1'b1;
                end else begin
                  walk_nxt  = '0;
                  state_nxt = S_CHECK;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CHECK: begin
        if (sq > cand_r) begin
          res_prime_nxt = 1'b1;
          state_nxt     = S_FIN;
        end else if (rd_data_r == '0) begin
          // A zero entry never divides: move on to the next entry.
          if (walk_inc == count_r) begin
            res_prime_nxt = 1'b1;
            state_nxt     = S_FIN;
          end else begin
            walk_nxt = walk_inc;
          end
        end else begin
          p_nxt     = rd_data_r;
          rem_nxt   = '0;
          dsh_nxt   = cand_r;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt  = rem_step;
        dsh_nxt  = dsh_step;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          if (rem_step == '0) begin
            res_div_nxt = p_r;
            state_nxt   = S_FIN;
          end else if (walk_inc == count_r) begin
            res_prime_nxt = 1'b1;
            state_nxt     = S_FIN;
          end else begin
            walk_nxt  = walk_inc;
            state_nxt = S_CHECK;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_prime_nxt  = res_prime_r;
          out_div_nxt    = res_div_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Writes happen only in the idle state and reads are used only during a
  // test, so a read never overlaps a write to the same entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= in_ch.value[PRIME_W-1:0];
    end
    rd_data_r <= mem[walk_nxt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r       <= cand_nxt;
    p_r          <= p_nxt;
    rem_r        <= rem_nxt;
    dsh_r        <= dsh_nxt;
    step_r       <= step_nxt;
    res_status_r <= res_status_nxt;
    res_prime_r  <= res_prime_nxt;
    res_div_r    <= res_div_nxt;
    out_status_r <= out_status_nxt;
    out_prime_r  <= out_prime_nxt;
    out_div_r    <= out_div_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("table count exceeds the table depth");

  a_walk_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK || state_r == S_DIV) |-> (walk_r < count_r))
    else $error("walk index beyond the filled part of the table");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while an item is still being worked");

  a_prime_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_prime_r) |-> (out_div_r == '0 && out_status_r == STATUS_OK))
    else $error("prime result carries a divisor or a load status");
endmodule

/* tb/prime_trial_division_tester_tb.sv */
// ----------------------------------------------------------------------------
// prime_trial_division_tester_tb: self-checking bench for the primality tester
// Drives clear, append and test items through the valid/ready input channel.
// An in-bench scoreboard keeps its own copy of the base-prime table and
// predicts every result, including rejected loads and unused kinds.
// Results are compared in order as they leave the block. Both channels idle
// and stall in random bursts, with one long receiver hold-off and sender
// drain pauses.
// ----------------------------------------------------------------------------
module prime_trial_division_tester_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptdt_pkg::*;

  localparam int DEPTH = DEFAULT_TABLE_DEPTH;
  localparam int ITEMS = 1400;
  localparam kind_t KIND_UNUSED = 2'd3;

  typedef struct packed {
    status_t status;
    logic    prime_flag;
    prime_t  divisor;
  } verdict_t;

  class primality_scoreboard;
    prime_t      table_copy [DEPTH];
    int unsigned base_count;
    verdict_t    awaited [$];
    int unsigned mismatch_count;

    function new();
      base_count     = 0;
      mismatch_count = 0;
    endfunction

    // Updates the table copy and queues the verdict this command produces.
    function void note_command(kind_t kind, value_t value);
      verdict_t        want;
      longint unsigned cand;
      longint unsigned p;
      int unsigned     j;
      want = '0;
      cand = value;
      case (kind)
        KIND_CLEAR: begin
          base_count = 0;
        end
        KIND_APPEND: begin
          if (value > 32'd65535) begin
            want.status = STATUS_TOO_LARGE;
          end else if (base_count >= DEPTH) begin
            want.status = STATUS_FULL;
          end else begin
            table_copy[base_count] = value[PRIME_W-1:0];
            base_count++;
          end
        end
        KIND_TEST: begin
          if (cand >= 2) begin
            want.prime_flag = 1'b1;
            for (j = 0; j < base_count; j++) begin
              p = table_copy[j];
              // The walk ends at the first entry past the square root,
              // even when later entries would be smaller.
              if (p * p > cand) break;
              if (p != 0 && cand % p == 0) begin
                want.prime_flag = 1'b0;
                want.divisor    = p[PRIME_W-1:0];
                break;
              end
            end
          end
        end
        default: begin
        end
      endcase
      awaited.push_back(want);
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      if (awaited.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status=%0d prime_flag=%0b divisor=%0d",
                   got.status, got.prime_flag, got.divisor);
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.prime_flag !== want.prime_flag ||
          got.divisor !== want.divisor) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display({"result mismatch: expected status=%0d prime_flag=%0b divisor=%0d,",
                    " got status=%0d prime_flag=%0b divisor=%0d"},
                   want.status, want.prime_flag, want.divisor,
                   got.status, got.prime_flag, got.divisor);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ptdt_in_if  in_ch ();
  ptdt_out_if out_ch ();

  prime_trial_division_tester #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  primality_scoreboard sb;
  int unsigned         items_sent;
  bit                  quiet;
  bit                  sender_calm;
  int unsigned         small_primes [DEPTH];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Caller is at a falling edge; returns at the falling edge after the item
  // is accepted, with valid still high.
  task automatic send_item(kind_t k, value_t v);
    if (!quiet && !sender_calm && $urandom_range(0, 6) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= k;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_command(k, v);
    items_sent++;
    quiet = (items_sent >= ITEMS - 150);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.awaited.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(verdict_t'({out_ch.status, out_ch.prime_flag, out_ch.divisor}));
  end

  // Result side: random stall bursts and one long hold-off that backs up
  // the block while the sender keeps offering items.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    bit          held;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    hold_left    = 0;
    held         = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && items_sent >= 400) begin
        held      = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int          phase;
    int          n;
    int          m;
    int          start;
    int          hi;
    int          i;
    int unsigned c;
    int unsigned d;
    int unsigned p;
    int unsigned q;
    bit          is_p;
    bit          full;
    kind_t       k;
    value_t      v;

    sb          = new();
    items_sent  = 0;
    quiet       = 1'b0;
    sender_calm = 1'b0;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind  = KIND_CLEAR;
    in_ch.value = '0;

    // The first DEPTH primes, used as table content and to build candidates.
    n = 0;
    c = 2;
    while (n < DEPTH) begin
      is_p = 1'b1;
      for (d = 2; d * d <= c; d++) begin
        if (c % d == 0) begin
          is_p = 1'b0;
          break;
        end
      end
      if (is_p) begin
        small_primes[n] = c;
        n++;
      end
      c++;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Empty table: below two is not prime, anything else is.
    sender_calm = 1'b1;
    send_item(KIND_TEST, 32'd0);
    send_item(KIND_TEST, 32'd1);
    send_item(KIND_TEST, 32'd2);
    send_item(KIND_TEST, 32'hFFFF_FFFF);
    send_item(KIND_UNUSED, 32'hFFFF_FFFF);
    send_item(KIND_APPEND, 32'h0001_0000);
    send_item(KIND_APPEND, 32'hFFFF_FFFF);
    // A zero entry is skipped and an entry of one divides everything.
    send_item(KIND_APPEND, 32'd0);
    send_item(KIND_APPEND, 32'd1);
    send_item(KIND_TEST, 32'd7);
    send_item(KIND_CLEAR, 32'hFFFF_FFFF);
    send_item(KIND_APPEND, 32'd2);
    send_item(KIND_APPEND, 32'd3);
    send_item(KIND_APPEND, 32'd5);
    send_item(KIND_APPEND, 32'd7);
    send_item(KIND_APPEND, 32'd65535);
    send_item(KIND_TEST, 32'd4);
    send_item(KIND_TEST, 32'd49);
    send_item(KIND_TEST, 32'hFFFF_FFFF);
    send_item(KIND_TEST, 32'd4294967291);
    // Unsorted table: the walk stops at 100 before it reaches 3.
    send_item(KIND_CLEAR, 32'd0);
    send_item(KIND_APPEND, 32'd100);
    send_item(KIND_APPEND, 32'd3);
    send_item(KIND_TEST, 32'd9);
    send_item(KIND_UNUSED, 32'd0);

    phase = 0;
    while (items_sent < ITEMS) begin
      if (phase % 4 == 3) wait_drained();
      full        = (phase == 2 || phase == 9);
      sender_calm = ($urandom_range(0, 4) == 0);
      if (full || sb.base_count > 32 || $urandom_range(0, 7) != 0)
        send_item(KIND_CLEAR, $urandom);
      n     = full ? DEPTH : $urandom_range(1, 24);
      start = (full || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(0, 40);
      hi    = start + n - 1;

      for (i = start; i <= hi; i++) begin
        k = KIND_APPEND;
        v = small_primes[i];
        if (!full) begin
          case ($urandom_range(0, 39))
            0: v = $urandom_range(0, 16'hFFFF);
            1: v = 32'd0;
            2: v = 32'd1;
            3: v = $urandom_range(32'h0001_0000, 32'hFFFF_FFFF);
            4: begin
              k = KIND_UNUSED;
              v = $urandom;
            end
            default: begin
            end
          endcase
        end
        send_item(k, v);
      end
      if (full) begin
        // The too-large check comes before the full check.
        send_item(KIND_APPEND, $urandom_range(0, 16'hFFFF));
        send_item(KIND_APPEND, $urandom_range(32'h0001_0000, 32'hFFFF_FFFF));
      end

      m = full ? 10 : $urandom_range(8, 40);
      for (i = 0; i < m; i++) begin
        p = small_primes[$urandom_range(start, hi)];
        q = small_primes[$urandom_range(start, hi)];
        k = KIND_TEST;
        case ($urandom_range(0, 11))
          0:       v = $urandom_range(0, 3);
          1:       v = p * q;
          2:       v = p * p;
          3:       v = p * p - 1;
          4:       v = p * p + 1;
          5, 6:    v = $urandom;
          7:       v = $urandom_range(0, 2700000);
          8:       v = $urandom_range(0, 10000);
          9:       v = 32'hFFFF_FFFF - $urandom_range(0, 100);
          10:      v = p * $urandom_range(1, 32'hFFFF_FFFF / p);
          default: begin
            k = $urandom_range(0, 1) ? KIND_UNUSED : KIND_APPEND;
            v = $urandom >> $urandom_range(0, 31);
          end
        endcase
        send_item(k, v);
      end
      phase++;
    end

    wait_drained();
    repeat (64) @(negedge clk);
    if (sb.mismatch_count == 0 && sb.awaited.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
